### design/mexp_pkg.sv
// mexp_pkg: shared types for the modular exponentiation unit
// status handshake between the top-level sequencer and the multiplier
// no dependencies
package mexp_pkg;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

### design/mexp_add_mod.sv
// mexp_add_mod: modular adder, (x + y) mod m, a modulus of zero wraps at WIDTH bits
// the one arithmetic unit shared by every step of the multiplier
// no dependencies
module mexp_add_mod #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_m,
    output logic [WIDTH-1:0] o_sum
);

    logic [WIDTH:0]   sum_full;
    logic [WIDTH+1:0] diff;

    assign sum_full = {1'b0, i_x} + {1'b0, i_y};
    // no borrow means the sum (carry included) reached the modulus
    assign diff     = {1'b0, sum_full} - {2'b00, i_m};
    assign o_sum    = diff[WIDTH+1] ? sum_full[WIDTH-1:0] : diff[WIDTH-1:0];

endmodule

### design/mexp_mul_mod.sv
// mexp_mul_mod: bit-serial modular multiplier, double and add, msb of b first
// one modular add per cycle through mexp_add_mod
// depends on mexp_pkg and mexp_add_mod
module mexp_mul_mod #(
    parameter int WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_b,
    input  logic [WIDTH-1:0]    i_m,
    output mexp_pkg::t_mul_stat o_stat,
    output logic [WIDTH-1:0]    o_product
);

    import mexp_pkg::*;

    localparam int CW = $clog2(WIDTH);

    typedef enum logic [1:0] {
        M_IDLE,
        M_DBL,
        M_ADD
    } t_mstate;

    t_mstate          r_state, n_state;
    logic [WIDTH-1:0] r_r, n_r;
    logic [WIDTH-1:0] r_b, n_b;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_done, n_done;

    logic [WIDTH-1:0] add_y;
    logic [WIDTH-1:0] add_sum;
    logic             bit_end;

    assign add_y = (r_state == M_ADD) ? i_a : r_r;

    mexp_add_mod #(.WIDTH(WIDTH)) u_add (
        .i_x   (r_r),
        .i_y   (add_y),
        .i_m   (i_m),
        .o_sum (add_sum)
    );

    // a bit of b is finished after its doubling, or after its add when set
    assign bit_end = (r_state == M_ADD) || ((r_state == M_DBL) && !r_b[WIDTH-1]);

    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_b     = r_b;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_r     = '0;
                    n_b     = i_b;
                    n_cnt   = CW'(WIDTH - 1);
                    n_state = M_DBL;
                end
            end
            M_DBL: begin
                n_r = add_sum;
                if (r_b[WIDTH-1]) begin
                    n_state = M_ADD;
                end
            end
            M_ADD: begin
                n_r = add_sum;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
        if (bit_end) begin
            if (r_cnt == '0) begin
                n_state = M_IDLE;
                n_done  = 1'b1;
            end else begin
                n_cnt   = r_cnt - 1'b1;
                n_b     = {r_b[WIDTH-2:0], 1'b0};
                n_state = M_DBL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_r   <= n_r;
        r_b   <= n_b;
        r_cnt <= n_cnt;
    end

    assign o_stat.busy = (r_state != M_IDLE);
    assign o_stat.done = r_done;
    assign o_product   = r_r;

endmodule

### design/modular_exponentiation_unit.sv
// modular_exponentiation_unit: base^exponent mod modulus, square and multiply, lsb first
// one transaction at a time, busy high from accept to the result strobe
// the serial modular multiplier (one add per cycle) sets the run time
// reset: synchronous active low, sequencer idle, modulus back to 1
module modular_exponentiation_unit #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command side
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_base_value,
    input  logic [WIDTH-1:0] i_exponent,
    // result side, one-cycle strobe
    output logic             o_result_valid,
    output logic [WIDTH-1:0] o_power_result,
    // modulus register write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [WIDTH-1:0] i_cfg_data
);

    import mexp_pkg::*;

    // sequencer states, each wait state names the product in flight
    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,      // base reduced as 1 * base mod m
        S_STEP,     // look at the next exponent bit
        S_ACC,      // acc = acc * base
        S_SQR       // base = base * base
    } t_state;

    t_state           r_state, n_state;
    logic             r_busy, n_busy;
    logic             r_valid, n_valid;
    logic [WIDTH-1:0] r_result, n_result;
    logic [WIDTH-1:0] r_mod, n_mod;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_base, n_base;
    logic [WIDTH-1:0] r_exp, n_exp;
    logic             r_mul_start, n_mul_start;

    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic [WIDTH-1:0] mul_product;
    t_mul_stat        mul_stat;
    logic             accept;
    logic             cfg_write;

    assign accept    = start && !r_busy;
    assign cfg_write = i_cfg_valid && o_cfg_ready;

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_RED: begin
                mul_a = WIDTH'(1);
                mul_b = r_base;
            end
            S_ACC: begin
                mul_a = r_acc;
                mul_b = r_base;
            end
            default: begin
                mul_a = r_base;
                mul_b = r_base;
            end
        endcase
    end

    mexp_mul_mod #(.WIDTH(WIDTH)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .i_m       (r_mod),
        .o_stat    (mul_stat),
        .o_product (mul_product)
    );

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_valid     = 1'b0;
        n_result    = r_result;
        n_mod       = r_mod;
        n_acc       = r_acc;
        n_base      = r_base;
        n_exp       = r_exp;
        n_mul_start = 1'b0;

        // modulus only changes between transactions
        if (cfg_write) begin
            n_mod = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_base      = i_base_value;
                    n_exp       = i_exponent;
                    n_acc       = WIDTH'(1);
                    n_busy      = 1'b1;
                    n_mul_start = 1'b1;
                    n_state     = S_RED;
                end
            end
            S_RED: begin
                if (mul_stat.done) begin
                    n_base  = mul_product;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (!mul_stat.busy) begin
                    if (r_exp == '0) begin
                        // no exponent bits left, zero exponent ends here with acc = 1
                        n_result = r_acc;
                        n_valid  = 1'b1;
                        n_busy   = 1'b0;
                        n_state  = S_IDLE;
                    end else if (r_exp[0]) begin
                        n_mul_start = 1'b1;
                        n_state     = S_ACC;
                    end else begin
                        n_mul_start = 1'b1;
                        n_state     = S_SQR;
                    end
                end
            end
            S_ACC: begin
                if (mul_stat.done) begin
                    n_acc       = mul_product;
                    n_mul_start = 1'b1;
                    n_state     = S_SQR;
                end
            end
            S_SQR: begin
                if (mul_stat.done) begin
                    n_base  = mul_product;
                    n_exp   = {1'b0, r_exp[WIDTH-1:1]};
                    n_state = S_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_valid     <= 1'b0;
            r_mul_start <= 1'b0;
            r_mod       <= WIDTH'(1);
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_valid     <= n_valid;
            r_mul_start <= n_mul_start;
            r_mod       <= n_mod;
        end
        r_result <= n_result;
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_exp    <= n_exp;
    end

    assign busy           = r_busy;
    assign o_result_valid = r_valid;
    assign o_power_result = r_result;
    assign o_cfg_ready    = !r_busy;

endmodule

### design/mexp_checker.sv
// mexp_checker: port-level checks on modular_exponentiation_unit
// bound to the top level at the end of this file, no package use
module mexp_checker #(
    parameter int WIDTH = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [WIDTH-1:0] i_base_value,
    input logic [WIDTH-1:0] i_exponent,
    input logic             o_result_valid,
    input logic [WIDTH-1:0] o_power_result,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [WIDTH-1:0] i_cfg_data
);

    // an accepted transaction makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // a result only closes a transaction that was in flight
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a transaction in flight");

    // the result strobe is a single pulse, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // modulus writes are only taken between transactions
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy)
        else $error("modulus write allowed while busy");

endmodule

bind modular_exponentiation_unit mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);
